/* rtl/skvt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types, operation codes and default sizes of the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int DEPTH_DEFAULT       = 256;
    localparam int KEY_WIDTH_DEFAULT   = 32;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 8;
    localparam int CAP_W    = 9;
    localparam int COUNT_W  = 9;
    localparam int GROUP    = 16;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UPSERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef struct packed {
        logic compare;
        logic sel_pos;
        logic do_insert;
        logic do_update;
        logic do_erase;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/skvt_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skvt_cell
// One slot of the sorted chain: holds a pair, compares it against the
// operation key and shifts with its neighbors on insert and erase.
// ----------------------------------------------------------------------------
module skvt_cell #(
    parameter int INDEX       = 0,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int CW          = 9
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire skvt_pkg::cell_cmd_t cmd,
    input  wire  [CW-1:0]           count,
    input  wire  [CW-1:0]           pos,
    input  wire  [KEY_WIDTH-1:0]    op_key,
    input  wire  [VALUE_WIDTH-1:0]  op_value,
    input  wire                     prev_lt,
    input  wire  [KEY_WIDTH-1:0]    prev_key,
    input  wire  [VALUE_WIDTH-1:0]  prev_value,
    input  wire  [KEY_WIDTH-1:0]    next_key,
    input  wire  [VALUE_WIDTH-1:0]  next_value,
    output logic                    lt,
    output logic [KEY_WIDTH-1:0]    cell_key,
    output logic [VALUE_WIDTH-1:0]  cell_value,
    output logic                    hit,
    output logic [KEY_WIDTH-1:0]    hit_key,
    output logic [VALUE_WIDTH-1:0]  hit_value
);
    import skvt_pkg::*;

    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic                   lt_reg;
    logic                   hit_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   occupied;

    assign occupied = MY_INDEX < count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else if (cmd.compare)
        begin
            lt_reg  <= occupied && (key_reg < op_key);
            hit_reg <= occupied && (cmd.sel_pos ? (pos == MY_INDEX) : (key_reg == op_key));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_insert && !lt_reg)
        begin
            key_reg   <= prev_lt ? op_key : prev_key;
            value_reg <= prev_lt ? op_value : prev_value;
        end
        else if (cmd.do_erase && !lt_reg)
        begin
            key_reg   <= next_key;
            value_reg <= next_value;
        end
        else if (cmd.do_update && hit_reg)
        begin
            value_reg <= op_value;
        end
    end

    assign lt         = lt_reg;
    assign cell_key   = key_reg;
    assign cell_value = value_reg;
    assign hit        = hit_reg;
    assign hit_key    = hit_reg ? key_reg : '0;
    assign hit_value  = hit_reg ? value_reg : '0;

endmodule

`default_nettype wire

/* rtl/skvt_reduce.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skvt_reduce
// Registered OR tree that gathers the single matching cell's flag and pair.
// ----------------------------------------------------------------------------
module skvt_reduce #(
    parameter int DEPTH       = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                     clk,
    input  wire                     load,
    input  wire                     hit       [DEPTH],
    input  wire  [KEY_WIDTH-1:0]    hit_key   [DEPTH],
    input  wire  [VALUE_WIDTH-1:0]  hit_value [DEPTH],
    output logic                    any_hit,
    output logic [KEY_WIDTH-1:0]    any_key,
    output logic [VALUE_WIDTH-1:0]  any_value
);
    import skvt_pkg::*;

    localparam int NUM_GROUPS = (DEPTH + GROUP - 1) / GROUP;

    logic                   grp_hit_reg   [NUM_GROUPS];
    logic [KEY_WIDTH-1:0]   grp_key_reg   [NUM_GROUPS];
    logic [VALUE_WIDTH-1:0] grp_value_reg [NUM_GROUPS];

    logic                   grp_hit_next   [NUM_GROUPS];
    logic [KEY_WIDTH-1:0]   grp_key_next   [NUM_GROUPS];
    logic [VALUE_WIDTH-1:0] grp_value_next [NUM_GROUPS];

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_hit_next[g]   = 1'b0;
            grp_key_next[g]   = '0;
            grp_value_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < DEPTH)
                begin
                    grp_hit_next[g]   = grp_hit_next[g] | hit[g * GROUP + j];
                    grp_key_next[g]   = grp_key_next[g] | hit_key[g * GROUP + j];
                    grp_value_next[g] = grp_value_next[g] | hit_value[g * GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                grp_hit_reg[g]   <= grp_hit_next[g];
                grp_key_reg[g]   <= grp_key_next[g];
                grp_value_reg[g] <= grp_value_next[g];
            end
        end
    end

    always_comb
    begin
        any_hit   = 1'b0;
        any_key   = '0;
        any_value = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            any_hit   = any_hit | grp_hit_reg[g];
            any_key   = any_key | grp_key_reg[g];
            any_value = any_value | grp_value_reg[g];
        end
    end

endmodule

`default_nettype wire

/* rtl/sorted_key_value_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Sorted key/value table built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each beat runs through a compare step, in which every cell compares its key
// at once, a reduce step for the registered OR tree that gathers the matching
// cell, and a finish step in which all cells shift or update together while
// the result register loads. A new beat is taken only once the previous one
// has reached the result register, so a beat is never accepted while another
// is in flight; a result waiting at the output holds the table in its last
// step until it is taken. The capacity register may be written only while
// the table is idle.
module sorted_key_value_table #(
    parameter int DEPTH       = skvt_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH   = skvt_pkg::KEY_WIDTH_DEFAULT,
    parameter int VALUE_WIDTH = skvt_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire  [skvt_pkg::CAP_W-1:0] cfg_wdata,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  [skvt_pkg::MODE_W-1:0] mode,
    input  wire  [KEY_WIDTH-1:0]    key,
    input  wire  [VALUE_WIDTH-1:0]  value,
    input  wire  [skvt_pkg::POS_W-1:0] position,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic                    ok,
    output logic [KEY_WIDTH-1:0]    out_key,
    output logic [VALUE_WIDTH-1:0]  out_value,
    output logic [skvt_pkg::COUNT_W-1:0] entry_count,
    output logic                    is_empty
);
    import skvt_pkg::*;

    localparam int DW = $clog2(DEPTH + 1);
    localparam int CW = (DW > COUNT_W) ? DW : COUNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_REDUCE,
        S_FINISH
    } state_t;

    state_t                 state_reg;
    logic [MODE_W-1:0]      mode_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [CW-1:0]          pos_reg;
    logic [CW-1:0]          count_reg;
    logic [CAP_W-1:0]       cap_reg;
    logic                   out_valid_reg;
    logic                   ok_reg;
    logic [KEY_WIDTH-1:0]   out_key_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;

    cell_cmd_t              cmd;
    logic                   fire;
    logic                   found;
    logic [KEY_WIDTH-1:0]   found_key;
    logic [VALUE_WIDTH-1:0] found_value;
    logic [CW-1:0]          limit;
    logic                   room;
    logic                   ins_ok;
    logic                   upd_ok;
    logic                   ers_ok;
    logic                   ok_next;
    logic [KEY_WIDTH-1:0]   out_key_next;
    logic [VALUE_WIDTH-1:0] out_value_next;
    logic [CW-1:0]          count_next;

    logic                   cell_lt    [DEPTH];
    logic [KEY_WIDTH-1:0]   cell_key   [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic                   cell_hit   [DEPTH];
    logic [KEY_WIDTH-1:0]   cell_hkey  [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_hval  [DEPTH];

    assign limit = (CW'(cap_reg) > DEPTH_C) ? DEPTH_C : CW'(cap_reg);
    assign room  = count_reg < limit;
    assign fire  = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        ins_ok         = 1'b0;
        upd_ok         = 1'b0;
        ers_ok         = 1'b0;
        ok_next        = 1'b0;
        out_key_next   = key_reg;
        out_value_next = '0;
        unique case (mode_reg)
            MODE_INSERT:
            begin
                ins_ok  = !found && room;
                ok_next = ins_ok;
            end
            MODE_UPDATE:
            begin
                upd_ok  = found;
                ok_next = found;
            end
            MODE_UPSERT:
            begin
                upd_ok  = found;
                ins_ok  = !found && room;
                ok_next = found || room;
            end
            MODE_ERASE:
            begin
                ers_ok  = found;
                ok_next = found;
            end
            MODE_LOOKUP:
            begin
                ok_next        = found;
                out_value_next = found_value;
            end
            MODE_READ:
            begin
                ok_next        = found;
                out_key_next   = found_key;
                out_value_next = found_value;
            end
            default:
            begin
                out_key_next = '0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ers_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        cmd.compare   = state_reg == S_COMPARE;
        cmd.sel_pos   = mode_reg == MODE_READ;
        cmd.do_insert = fire && ins_ok;
        cmd.do_update = fire && upd_ok;
        cmd.do_erase  = fire && ers_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready && !fire)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_COMPARE;
                    end
                end
                S_COMPARE:
                begin
                    state_reg <= S_REDUCE;
                end
                S_REDUCE:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (fire)
                    begin
                        state_reg     <= S_IDLE;
                        count_reg     <= count_next;
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            mode_reg  <= mode;
            key_reg   <= key;
            value_reg <= value;
            pos_reg   <= CW'(position);
        end
        if (fire)
        begin
            ok_reg        <= ok_next;
            out_key_reg   <= out_key_next;
            out_value_reg <= out_value_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                   p_lt;
        logic [KEY_WIDTH-1:0]   p_key;
        logic [VALUE_WIDTH-1:0] p_value;
        logic [KEY_WIDTH-1:0]   n_key;
        logic [VALUE_WIDTH-1:0] n_value;

        if (i == 0)
        begin : g_first
            assign p_lt    = 1'b1;
            assign p_key   = key_reg;
            assign p_value = value_reg;
        end
        else
        begin : g_mid
            assign p_lt    = cell_lt[i-1];
            assign p_key   = cell_key[i-1];
            assign p_value = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign n_key   = cell_key[i];
            assign n_value = cell_value[i];
        end
        else
        begin : g_inner
            assign n_key   = cell_key[i+1];
            assign n_value = cell_value[i+1];
        end

        skvt_cell #(
            .INDEX       (i),
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CW          (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .count      (count_reg),
            .pos        (pos_reg),
            .op_key     (key_reg),
            .op_value   (value_reg),
            .prev_lt    (p_lt),
            .prev_key   (p_key),
            .prev_value (p_value),
            .next_key   (n_key),
            .next_value (n_value),
            .lt         (cell_lt[i]),
            .cell_key   (cell_key[i]),
            .cell_value (cell_value[i]),
            .hit        (cell_hit[i]),
            .hit_key    (cell_hkey[i]),
            .hit_value  (cell_hval[i])
        );
    end

    skvt_reduce #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_reduce (
        .clk       (clk),
        .load      (state_reg == S_REDUCE),
        .hit       (cell_hit),
        .hit_key   (cell_hkey),
        .hit_value (cell_hval),
        .any_hit   (found),
        .any_key   (found_key),
        .any_value (found_value)
    );

    assign in_ready    = state_reg == S_IDLE;
    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign out_key     = out_key_reg;
    assign out_value   = out_value_reg;
    assign entry_count = count_reg[COUNT_W-1:0];
    assign is_empty    = count_reg == '0;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted key/value table. A queue of pending
// operations feeds a valid/ready driver, and a shadow sorted table predicts
// every result beat. A monitor compares each result field by field.
// Capacity is changed between phases while the table is idle. Random idle
// bursts are applied on both channels, and one long stall on the output.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import skvt_pkg::*;

    localparam int KW        = KEY_WIDTH_DEFAULT;
    localparam int VW        = VALUE_WIDTH_DEFAULT;
    localparam int DEPTH_N   = DEPTH_DEFAULT;
    localparam int POOL_N    = 64;
    localparam int STALL_AT  = 400;
    localparam int STALL_LEN = 300;
    localparam int MAX_PRINT = 40;

    localparam logic [MODE_W-1:0] MODE_NOP_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_NOP_B = 3'd7;

    localparam int PROFILE_MIXED = 0;
    localparam int PROFILE_FILL  = 1;
    localparam int PROFILE_DRAIN = 2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KW-1:0]     key;
        logic [VW-1:0]     value;
        logic [POS_W-1:0]  position;
    } tbl_op_t;

    typedef struct packed {
        logic               ok;
        logic [KW-1:0]      out_key;
        logic [VW-1:0]      out_value;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } tbl_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CAP_W-1:0]     cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [MODE_W-1:0]    mode = '0;
    logic [KW-1:0]        key = '0;
    logic [VW-1:0]        value = '0;
    logic [POS_W-1:0]     position = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 ok;
    logic [KW-1:0]        out_key;
    logic [VW-1:0]        out_value;
    logic [COUNT_W-1:0]   entry_count;
    logic                 is_empty;

    logic [KW-1:0] shadow_keys [DEPTH_N];
    logic [VW-1:0] shadow_vals [DEPTH_N];
    int            shadow_count = 0;
    int            capacity_reg = int'(CAP_RESET);
    int            peak_count = 0;

    tbl_op_t       pending_ops [$];
    tbl_reply_t    expected_replies [$];
    tbl_op_t       cur_op;
    tbl_reply_t    reply_want;
    logic [KW-1:0] key_pool [POOL_N];

    int outstanding = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;
    bit idle_on = 1'b1;
    int err_count = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int cap_writes = 0;

    sorted_key_value_table uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .key         (key),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .out_key     (out_key),
        .out_value   (out_value),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void shadow_insert_at(int idx, logic [KW-1:0] k, logic [VW-1:0] v);
        int i;
        for (i = shadow_count; i > idx; i--)
        begin
            shadow_keys[i] = shadow_keys[i - 1];
            shadow_vals[i] = shadow_vals[i - 1];
        end
        shadow_keys[idx] = k;
        shadow_vals[idx] = v;
        shadow_count++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
    endfunction

    function automatic tbl_reply_t table_apply(tbl_op_t op);
        tbl_reply_t rsp;
        int         lim;
        int         idx;
        int         j;
        bit         found;
        lim = (capacity_reg > DEPTH_N) ? DEPTH_N : capacity_reg;
        idx = 0;
        while (idx < shadow_count && shadow_keys[idx] < op.key)
            idx++;
        found = (idx < shadow_count) && (shadow_keys[idx] == op.key);
        rsp.ok = 1'b0;
        rsp.out_key = op.key;
        rsp.out_value = '0;
        case (op.mode)
            MODE_INSERT:
            begin
                if (!found && shadow_count < lim)
                begin
                    shadow_insert_at(idx, op.key, op.value);
                    rsp.ok = 1'b1;
                end
            end
            MODE_UPDATE, MODE_UPSERT:
            begin
                if (found)
                begin
                    shadow_vals[idx] = op.value;
                    rsp.ok = 1'b1;
                end
                else if (op.mode == MODE_UPSERT && shadow_count < lim)
                begin
                    shadow_insert_at(idx, op.key, op.value);
                    rsp.ok = 1'b1;
                end
            end
            MODE_ERASE:
            begin
                if (found)
                begin
                    for (j = idx; j + 1 < shadow_count; j++)
                    begin
                        shadow_keys[j] = shadow_keys[j + 1];
                        shadow_vals[j] = shadow_vals[j + 1];
                    end
                    shadow_count--;
                    rsp.ok = 1'b1;
                end
            end
            MODE_LOOKUP:
            begin
                if (found)
                begin
                    rsp.ok = 1'b1;
                    rsp.out_value = shadow_vals[idx];
                end
            end
            MODE_READ:
            begin
                if (int'(op.position) < shadow_count)
                begin
                    rsp.ok = 1'b1;
                    rsp.out_key = shadow_keys[op.position];
                    rsp.out_value = shadow_vals[op.position];
                end
                else
                    rsp.out_key = '0;
            end
            default:
                rsp.out_key = '0;
        endcase
        rsp.entry_count = shadow_count[COUNT_W-1:0];
        rsp.is_empty = (shadow_count == 0);
        return rsp;
    endfunction

    task automatic log_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINT)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            log_mismatch($sformatf("result beat %0d field %s: got %0h, expected %0h",
                                   beats_checked, name, got, want));
    endtask

    // Operation driver: a beat is offered from the pending queue and held until taken.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                expected_replies.push_back(table_apply(cur_op));
                beats_sent++;
            end
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_ops.size() == 0)
                in_valid <= 1'b0;
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 17);
                in_valid <= 1'b0;
            end
            else
            begin
                cur_op = pending_ops.pop_front();
                outstanding++;
                mode <= cur_op.mode;
                key <= cur_op.key;
                value <= cur_op.value;
                position <= cur_op.position;
                in_valid <= 1'b1;
            end
        end
    end

    // Result monitor with random back-pressure and one long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                    log_mismatch("result beat arrived with no expectation pending");
                else
                begin
                    reply_want = expected_replies.pop_front();
                    check_field("ok", 64'(ok), 64'(reply_want.ok));
                    check_field("out_key", 64'(out_key), 64'(reply_want.out_key));
                    check_field("out_value", 64'(out_value), 64'(reply_want.out_value));
                    check_field("entry_count", 64'(entry_count),
                                64'(reply_want.entry_count));
                    check_field("is_empty", 64'(is_empty), 64'(reply_want.is_empty));
                    beats_checked++;
                    outstanding--;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!stall_done && beats_checked >= STALL_AT)
            begin
                stall_done = 1'b1;
                stall_left = STALL_LEN - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 17);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic push_op(logic [MODE_W-1:0] m, logic [KW-1:0] k, logic [VW-1:0] v,
                           logic [POS_W-1:0] p);
        tbl_op_t op;
        op.mode = m;
        op.key = k;
        op.value = v;
        op.position = p;
        pending_ops.push_back(op);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_ops.size() != 0 || outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_capacity(int c);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= c[CAP_W-1:0];
        capacity_reg = c & ((1 << CAP_W) - 1);
        @(posedge clk);
        cfg_we <= 1'b0;
        cap_writes++;
    endtask

    function automatic tbl_op_t make_op(int pool_n, int profile);
        tbl_op_t op;
        int      r;
        int      k_roll;
        r = $urandom_range(0, 99);
        k_roll = $urandom_range(0, 99);
        if (profile == PROFILE_FILL)
        begin
            if (r < 75)      op.mode = MODE_INSERT;
            else if (r < 80) op.mode = MODE_UPSERT;
            else if (r < 85) op.mode = MODE_LOOKUP;
            else if (r < 95) op.mode = MODE_READ;
            else if (r < 98) op.mode = MODE_UPDATE;
            else             op.mode = ($urandom_range(0, 1) != 0) ? MODE_NOP_A : MODE_NOP_B;
            op.key = (k_roll < 60) ? $urandom() : key_pool[$urandom_range(0, pool_n - 1)];
        end
        else
        begin
            if (profile == PROFILE_DRAIN)
            begin
                if (r < 10)      op.mode = MODE_INSERT;
                else if (r < 20) op.mode = MODE_UPSERT;
                else if (r < 28) op.mode = MODE_UPDATE;
                else if (r < 55) op.mode = MODE_ERASE;
                else if (r < 70) op.mode = MODE_LOOKUP;
                else if (r < 95) op.mode = MODE_READ;
                else             op.mode = ($urandom_range(0, 1) != 0) ? MODE_NOP_A : MODE_NOP_B;
            end
            else
            begin
                if (r < 25)      op.mode = MODE_INSERT;
                else if (r < 37) op.mode = MODE_UPSERT;
                else if (r < 47) op.mode = MODE_UPDATE;
                else if (r < 62) op.mode = MODE_ERASE;
                else if (r < 77) op.mode = MODE_LOOKUP;
                else if (r < 95) op.mode = MODE_READ;
                else             op.mode = ($urandom_range(0, 1) != 0) ? MODE_NOP_A : MODE_NOP_B;
            end
            op.key = (k_roll < 85) ? key_pool[$urandom_range(0, pool_n - 1)] : $urandom();
        end
        op.value = $urandom();
        if ($urandom_range(0, 99) < 70)
            op.position = POS_W'($urandom_range(0, pool_n));
        else
            op.position = POS_W'($urandom_range(0, 255));
        return op;
    endfunction

    task automatic run_random(int n, int pool_n, int profile, bit with_idle);
        int i;
        idle_on = with_idle;
        for (i = 0; i < n; i++)
            pending_ops.push_back(make_op(pool_n, profile));
    endtask

    initial
    begin
        int i;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (i = 2; i < POOL_N; i++)
            key_pool[i] = $urandom();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        push_op(MODE_READ,   32'h0,         32'h0,         8'd0);
        push_op(MODE_LOOKUP, 32'h5,         32'h0,         8'd0);
        push_op(MODE_ERASE,  32'h5,         32'h0,         8'd0);
        push_op(MODE_UPDATE, 32'h5,         32'h1,         8'd0);
        push_op(MODE_INSERT, 32'h0,         32'hFFFF_FFFF, 8'd0);
        push_op(MODE_INSERT, 32'hFFFF_FFFF, 32'h0,         8'd0);
        push_op(MODE_INSERT, 32'h0,         32'h7,         8'd0);
        push_op(MODE_INSERT, 32'h8000_0000, 32'h1234,      8'd0);
        push_op(MODE_INSERT, 32'h7FFF_FFFF, 32'h4321,      8'd0);
        push_op(MODE_UPDATE, 32'h0,         32'hA5A5_A5A5, 8'd0);
        push_op(MODE_UPSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 8'd0);
        push_op(MODE_UPSERT, 32'd100,       32'd99,        8'd0);
        push_op(MODE_LOOKUP, 32'h8000_0000, 32'h0,         8'd0);
        push_op(MODE_LOOKUP, 32'h8000_0001, 32'h0,         8'd0);
        push_op(MODE_READ,   32'h0,         32'h0,         8'd0);
        push_op(MODE_READ,   32'h0,         32'h0,         8'd2);
        push_op(MODE_READ,   32'h0,         32'h0,         8'd4);
        push_op(MODE_READ,   32'h0,         32'h0,         8'd5);
        push_op(MODE_READ,   32'h0,         32'h0,         8'd255);
        push_op(MODE_ERASE,  32'h8000_0000, 32'h0,         8'd0);
        push_op(MODE_ERASE,  32'h8000_0000, 32'h0,         8'd0);
        push_op(MODE_ERASE,  32'h0,         32'h0,         8'd0);
        push_op(MODE_NOP_A,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        push_op(MODE_NOP_B,  32'h1,         32'h1,         8'h1);
        push_op(MODE_READ,   32'h0,         32'h0,         8'd0);

        set_capacity(0);
        run_random(60, 16, PROFILE_MIXED, 1'b1);
        set_capacity(4);
        run_random(150, 12, PROFILE_MIXED, 1'b1);
        set_capacity(300);
        run_random(420, POOL_N, PROFILE_FILL, 1'b1);
        set_capacity(511);
        run_random(120, POOL_N, PROFILE_MIXED, 1'b0);
        wait_idle();
        repeat ($urandom_range(5, 40)) @(posedge clk);
        run_random(120, POOL_N, PROFILE_MIXED, 1'b1);
        set_capacity(1);
        run_random(100, 8, PROFILE_MIXED, 1'b1);
        set_capacity(256);
        run_random(200, 32, PROFILE_DRAIN, 1'b0);
        wait_idle();
        repeat (20) @(posedge clk);

        $display("Run covered %0d operation beats and %0d checked result beats across %0d capacity writes.",
                 beats_sent, beats_checked, cap_writes);
        $display("Peak predicted occupancy was %0d of %0d entries; %0d mismatches seen.",
                 peak_count, DEPTH_N, err_count);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout with %0d result beats still outstanding.", outstanding);
        $display("Test completed with failures");
        $finish;
    end

endmodule
